>>> design/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types, constants and tables for the breath stepper pulse controller.
// ----------------------------------------------------------------------------
package bsp_pkg;

	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int RATE_W    = 6;
	localparam int VOL_W     = 2;
	localparam int MODE_W    = 2;
	localparam int DEG_W     = 10;
	localparam int TMO_W     = 26;
	localparam int STEPS_W   = 10;
	localparam int HALF_W    = 25;
	localparam int DIV_STEPS = HALF_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int DEG10_W   = 14;
	localparam int RECIP_W   = 13;
	localparam int PROD_W    = DEG10_W + RECIP_W;
	localparam int RECIP_SH  = 16;

	localparam logic [RECIP_W-1:0] RECIP_9   = 13'd7282;
	localparam logic [STEPS_W-1:0] STEPS_MAX = 10'd1023;

	localparam logic [RATE_W-1:0] RST_BPM     = 6'd12;
	localparam logic [VOL_W-1:0]  RST_VOL     = 2'd0;
	localparam logic [MODE_W-1:0] RST_MODE    = 2'd0;
	localparam logic [DEG_W-1:0]  RST_DEG_S   = 10'd195;
	localparam logic [DEG_W-1:0]  RST_DEG_M   = 10'd390;
	localparam logic [DEG_W-1:0]  RST_DEG_L   = 10'd584;
	localparam logic [TMO_W-1:0]  RST_TIMEOUT = 26'd30000000;

	localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CTRL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TRIG = 2'd2;

	localparam logic [VOL_W-1:0] VOL_SMALL  = 2'd0;
	localparam logic [VOL_W-1:0] VOL_MEDIUM = 2'd1;

	typedef enum logic [2:0] {
		REG_BPM     = 3'd0,
		REG_VOL     = 3'd1,
		REG_MODE    = 3'd2,
		REG_DEG_S   = 3'd3,
		REG_DEG_M   = 3'd4,
		REG_DEG_L   = 3'd5,
		REG_TIMEOUT = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_INHALE = 2'd1,
		PH_EXHALE = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEPS,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic [RATE_W-1:0] bpm;
		logic [VOL_W-1:0]  vol;
		logic [MODE_W-1:0] mode;
		logic [DEG_W-1:0]  deg_s;
		logic [DEG_W-1:0]  deg_m;
		logic [DEG_W-1:0]  deg_l;
		logic [TMO_W-1:0]  timeout;
	} cfg_t;

	typedef struct packed {
		logic tick;
		logic load_steps;
		logic div_start;
		logic load_breath;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic start_now;
		logic div_busy;
		logic out_free;
	} status_t;

	function automatic logic [HALF_W-1:0] part_of_rate(input logic [RATE_W-1:0] r);
		logic [HALF_W-1:0] p;
		begin
			unique case (r)
				6'd0, 6'd1: p = 25'd20000000;
				6'd2:  p = 25'd10000000;
				6'd3:  p = 25'd6666666;
				6'd4:  p = 25'd5000000;
				6'd5:  p = 25'd4000000;
				6'd6:  p = 25'd3333333;
				6'd7:  p = 25'd2857142;
				6'd8:  p = 25'd2500000;
				6'd9:  p = 25'd2222222;
				6'd10: p = 25'd2000000;
				6'd11: p = 25'd1818181;
				6'd12: p = 25'd1666666;
				6'd13: p = 25'd1538461;
				6'd14: p = 25'd1428571;
				6'd15: p = 25'd1333333;
				6'd16: p = 25'd1250000;
				6'd17: p = 25'd1176470;
				6'd18: p = 25'd1111111;
				6'd19: p = 25'd1052631;
				6'd20: p = 25'd1000000;
				6'd21: p = 25'd952380;
				6'd22: p = 25'd909090;
				6'd23: p = 25'd869565;
				6'd24: p = 25'd833333;
				6'd25: p = 25'd800000;
				6'd26: p = 25'd769230;
				6'd27: p = 25'd740740;
				6'd28: p = 25'd714285;
				6'd29: p = 25'd689655;
				6'd30: p = 25'd666666;
				6'd31: p = 25'd645161;
				6'd32: p = 25'd625000;
				6'd33: p = 25'd606060;
				6'd34: p = 25'd588235;
				6'd35: p = 25'd571428;
				6'd36: p = 25'd555555;
				6'd37: p = 25'd540540;
				6'd38: p = 25'd526315;
				6'd39: p = 25'd512820;
				6'd40: p = 25'd500000;
				6'd41: p = 25'd487804;
				6'd42: p = 25'd476190;
				6'd43: p = 25'd465116;
				6'd44: p = 25'd454545;
				6'd45: p = 25'd444444;
				6'd46: p = 25'd434782;
				6'd47: p = 25'd425531;
				6'd48: p = 25'd416666;
				6'd49: p = 25'd408163;
				6'd50: p = 25'd400000;
				6'd51: p = 25'd392156;
				6'd52: p = 25'd384615;
				6'd53: p = 25'd377358;
				6'd54: p = 25'd370370;
				6'd55: p = 25'd363636;
				6'd56: p = 25'd357142;
				6'd57: p = 25'd350877;
				6'd58: p = 25'd344827;
				6'd59: p = 25'd338983;
				6'd60: p = 25'd333333;
				6'd61: p = 25'd327868;
				6'd62: p = 25'd322580;
				6'd63: p = 25'd317460;
				default: p = 25'd20000000;
			endcase
			return p;
		end
	endfunction

endpackage

>>> design/bsp_div.sv
// ----------------------------------------------------------------------------
// bsp_div
// Restoring divider, one quotient bit per cycle, for the step half-period.
// ----------------------------------------------------------------------------
module bsp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bsp_pkg::HALF_W-1:0]  dividend,
	input  logic [bsp_pkg::STEPS_W-1:0] divisor,
	output logic [bsp_pkg::HALF_W-1:0]  quotient,
	output logic                       busy
);
	import bsp_pkg::*;

	logic [STEPS_W-1:0]   rem_q;
	logic [HALF_W-1:0]    quo_q;
	logic [STEPS_W-1:0]   dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [STEPS_W:0]     shifted;
	logic [STEPS_W:0]     diff;
	logic                 ge;

	assign shifted = {rem_q, quo_q[HALF_W-1]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dsr_q  <= divisor;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			rem_q <= ge ? diff[STEPS_W-1:0] : shifted[STEPS_W-1:0];
			quo_q <= {quo_q[HALF_W-2:0], ge};
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;

endmodule

>>> design/bsp_ctrl.sv
// ----------------------------------------------------------------------------
// bsp_ctrl
// Sequencer: takes a tick item, runs breath-start setup when a breath starts, emits the result.
// ----------------------------------------------------------------------------
module bsp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bsp_pkg::status_t  status,
	output bsp_pkg::cmd_t     cmd
);
	import bsp_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.tick = 1'b1;
					state_d  = status.start_now ? ST_STEPS : ST_EMIT;
				end
			end
			ST_STEPS: begin
				cmd.load_steps = 1'b1;
				state_d        = ST_DIV_START;
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (!status.div_busy) begin
					cmd.load_breath = 1'b1;
					state_d         = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> design/bsp_dp.sv
// ----------------------------------------------------------------------------
// bsp_dp
// Datapath: watchdog, trigger latch, breath setup, pulse timing, result reg.
// ----------------------------------------------------------------------------
module bsp_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bsp_pkg::cfg_t               cfg,
	input  bsp_pkg::cmd_t               cmd,
	input  logic                        trigger_request,
	input  logic [bsp_pkg::HALF_W-1:0]  div_quo,
	output logic [bsp_pkg::HALF_W-1:0]  div_dividend,
	output logic [bsp_pkg::STEPS_W-1:0] div_divisor,
	output logic                        start_now,
	output logic                        out_free,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        step_level,
	output logic                        direction_level,
	output logic                        apnea_alarm,
	output logic                        breath_active
);
	import bsp_pkg::*;

	phase_t             phase_q;
	logic [STEPS_W-1:0] steps_total_q;
	logic [STEPS_W-1:0] steps_done_q;
	logic [HALF_W-1:0]  inh_half_q;
	logic [HALF_W-1:0]  exh_half_q;
	logic [HALF_W-1:0]  interval_q;
	logic               pin_high_q;
	logic [TMO_W-1:0]   wd_q;
	logic               pend_q;
	logic               alarm_q;
	logic [HALF_W-1:0]  part_q;
	logic               out_valid_q;
	logic               step_q;
	logic               dir_q;
	logic               alarm_out_q;
	logic               active_q;

	logic [TMO_W:0]     wd_inc;
	logic               wd_hit;
	logic               pend_now;
	logic               phase_idle;
	logic [DEG_W-1:0]   deg_sel;
	logic [DEG10_W-1:0] deg10;
	logic [PROD_W-1:0]  prod;
	logic [STEPS_W:0]   steps_raw;
	logic [STEPS_W-1:0] steps_sat;
	logic [HALF_W-1:0]  quo_half;
	logic [HALF_W-1:0]  half;
	logic [HALF_W-1:0]  int_inc;
	logic [STEPS_W-1:0] done_inc;
	logic               active;

	assign wd_inc     = {1'b0, wd_q} + 1'b1;
	assign wd_hit     = wd_inc >= {1'b0, cfg.timeout};
	assign pend_now   = pend_q | wd_hit | trigger_request;
	assign phase_idle = phase_q == PH_IDLE;
	assign start_now  = phase_idle &&
		(cfg.mode == MODE_CTRL || (cfg.mode == MODE_TRIG && pend_now));

	always_comb begin
		priority if (cfg.vol == VOL_SMALL) begin
			deg_sel = cfg.deg_s;
		end else if (cfg.vol == VOL_MEDIUM) begin
			deg_sel = cfg.deg_m;
		end else begin
			deg_sel = cfg.deg_l;
		end
	end

	assign deg10     = {1'b0, deg_sel, 3'b000} + {3'b000, deg_sel, 1'b0};
	assign prod      = PROD_W'(deg10) * PROD_W'(RECIP_9);
	assign steps_raw = prod[RECIP_SH +: STEPS_W+1];

	always_comb begin
		priority if (steps_raw > {1'b0, STEPS_MAX}) begin
			steps_sat = STEPS_MAX;
		end else if (steps_raw == '0) begin
			steps_sat = STEPS_W'(1);
		end else begin
			steps_sat = steps_raw[STEPS_W-1:0];
		end
	end

	assign quo_half = div_quo >> 1;
	assign active   = !phase_idle;
	assign half     = (phase_q == PH_INHALE) ? inh_half_q : exh_half_q;
	assign int_inc  = interval_q + 1'b1;
	assign done_inc = steps_done_q + 1'b1;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			steps_total_q <= '0;
			steps_done_q  <= '0;
			inh_half_q    <= '0;
			exh_half_q    <= '0;
			interval_q    <= '0;
			pin_high_q    <= 1'b0;
			wd_q          <= '0;
			pend_q        <= 1'b0;
			alarm_q       <= 1'b0;
			part_q        <= '0;
		end else begin
			if (cmd.tick) begin
				alarm_q <= wd_hit;
				wd_q    <= wd_hit ? '0 : wd_inc[TMO_W-1:0];
				pend_q  <= phase_idle ? 1'b0 : pend_now;
			end
			if (cmd.load_steps) begin
				steps_total_q <= steps_sat;
				part_q        <= part_of_rate(cfg.bpm);
			end
			if (cmd.load_breath) begin
				inh_half_q   <= (div_quo == '0) ? HALF_W'(1) : div_quo;
				exh_half_q   <= (quo_half == '0) ? HALF_W'(1) : quo_half;
				phase_q      <= PH_INHALE;
				steps_done_q <= '0;
				interval_q   <= '0;
				pin_high_q   <= 1'b1;
			end
			if (cmd.emit && active) begin
				if (int_inc >= half) begin
					interval_q <= '0;
					if (pin_high_q) begin
						pin_high_q <= 1'b0;
					end else if (done_inc >= steps_total_q) begin
						steps_done_q <= '0;
						if (phase_q == PH_INHALE) begin
							phase_q    <= PH_EXHALE;
							pin_high_q <= 1'b1;
						end else begin
							phase_q    <= PH_IDLE;
							pin_high_q <= 1'b0;
							wd_q       <= '0;
						end
					end else begin
						steps_done_q <= done_inc;
						pin_high_q   <= 1'b1;
					end
				end else begin
					interval_q <= int_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= 1'b0;
			dir_q       <= 1'b0;
			alarm_out_q <= 1'b0;
			active_q    <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
			step_q      <= active && pin_high_q;
			dir_q       <= phase_q == PH_INHALE;
			alarm_out_q <= alarm_q;
			active_q    <= active;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign div_dividend    = part_q;
	assign div_divisor     = steps_total_q;
	assign out_valid       = out_valid_q;
	assign step_level      = step_q;
	assign direction_level = dir_q;
	assign apnea_alarm     = alarm_out_q;
	assign breath_active   = active_q;

endmodule

>>> design/breath_stepper_pulse_controller.sv
// ----------------------------------------------------------------------------
// breath_stepper_pulse_controller
// Ventilator stepper pulse generator with apnea watchdog, one result per tick.
// ----------------------------------------------------------------------------
// Ordinary tick: the accept moves the sequencer to its emit state, and the result
// is registered once the output is free; one item is handled at a time.
// Breath-start tick: step count and rate part are loaded, the 25-step bit-serial
// divider runs, then the breath is loaded and the result is emitted.
// Reset (arst_n low, asynchronous): phase idle, all counters and latches clear,
// configuration registers at their default values.
// ----------------------------------------------------------------------------
module breath_stepper_pulse_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bsp_pkg::ADDR_W-1:0]  paddr,
	input  logic [bsp_pkg::DATA_W-1:0]  pwdata,
	output logic [bsp_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        trigger_request,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        step_level,
	output logic                        direction_level,
	output logic                        apnea_alarm,
	output logic                        breath_active
);
	import bsp_pkg::*;

	cfg_t              cfg_q;
	cmd_t              cmd;
	status_t           status;
	reg_idx_t          idx;
	logic              wr_en;
	logic              start_now;
	logic              out_free;
	logic              div_busy;
	logic [HALF_W-1:0]  div_quo;
	logic [HALF_W-1:0]  div_dividend;
	logic [STEPS_W-1:0] div_divisor;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bpm     <= RST_BPM;
			cfg_q.vol     <= RST_VOL;
			cfg_q.mode    <= RST_MODE;
			cfg_q.deg_s   <= RST_DEG_S;
			cfg_q.deg_m   <= RST_DEG_M;
			cfg_q.deg_l   <= RST_DEG_L;
			cfg_q.timeout <= RST_TIMEOUT;
		end else if (wr_en) begin
			unique case (idx)
				REG_BPM:     cfg_q.bpm     <= pwdata[RATE_W-1:0];
				REG_VOL:     cfg_q.vol     <= pwdata[VOL_W-1:0];
				REG_MODE:    cfg_q.mode    <= pwdata[MODE_W-1:0];
				REG_DEG_S:   cfg_q.deg_s   <= pwdata[DEG_W-1:0];
				REG_DEG_M:   cfg_q.deg_m   <= pwdata[DEG_W-1:0];
				REG_DEG_L:   cfg_q.deg_l   <= pwdata[DEG_W-1:0];
				REG_TIMEOUT: cfg_q.timeout <= pwdata[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BPM:     prdata = DATA_W'(cfg_q.bpm);
			REG_VOL:     prdata = DATA_W'(cfg_q.vol);
			REG_MODE:    prdata = DATA_W'(cfg_q.mode);
			REG_DEG_S:   prdata = DATA_W'(cfg_q.deg_s);
			REG_DEG_M:   prdata = DATA_W'(cfg_q.deg_m);
			REG_DEG_L:   prdata = DATA_W'(cfg_q.deg_l);
			REG_TIMEOUT: prdata = DATA_W'(cfg_q.timeout);
			default:     prdata = '0;
		endcase
	end

	assign status.start_now = start_now;
	assign status.div_busy  = div_busy;
	assign status.out_free  = out_free;

	bsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.busy     (div_busy)
	);

	bsp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.cmd             (cmd),
		.trigger_request (trigger_request),
		.div_quo         (div_quo),
		.div_dividend    (div_dividend),
		.div_divisor     (div_divisor),
		.start_now       (start_now),
		.out_free        (out_free),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.step_level      (step_level),
		.direction_level (direction_level),
		.apnea_alarm     (apnea_alarm),
		.breath_active   (breath_active)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in flight");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !breath_active |-> !step_level && !direction_level)
		else $error("step or direction driven outside a breath");

	a_div_setup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy && div_divisor != '0)
		else $error("divider started while busy or with zero step count");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the breath stepper pulse controller.
// Microsecond ticks go in on a valid/ready stream and one set of pin levels
// comes back per tick. Each tick is run through a local model of the breath
// sequencer and apnea watchdog, and the returned pins are compared in order.
// Registers are set over APB between phases. A short table of directed ticks
// comes first, then random phases in the idle modes and one long breath.
// ----------------------------------------------------------------------------
module tb_top;
	import bsp_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int SETTLE       = 64;
	localparam int SEG_ITEMS    = 100;
	localparam int SEGMENTS     = 8;
	localparam int BREATH_SEG   = 3;
	localparam int SWAP_SEG     = 3;
	localparam int CALM_SEG     = 6;
	localparam int REPORT_MAX   = 10;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam logic [VOL_W-1:0]  VOL_SPARE  = 2'd3;

	localparam int unsigned PART_NUM  = 20000000;
	localparam int unsigned STEPS_REV = 400;
	localparam int unsigned DEG_REV   = 360;

	typedef struct packed {
		logic step;
		logic dir;
		logic alarm;
		logic active;
	} pins_t;

	localparam pins_t PINS_QUIET = 4'b0000;
	localparam pins_t PINS_ALARM = 4'b0010;

	typedef struct packed {
		logic              is_write;
		reg_idx_t          idx;
		logic [DATA_W-1:0] val;
		logic              trig;
		logic              typed;
		pins_t             want;
	} plan_row_t;

	logic              clk             = 1'b0;
	logic              arst_n          = 1'b0;
	logic              psel            = 1'b0;
	logic              penable         = 1'b0;
	logic              pwrite          = 1'b0;
	logic [ADDR_W-1:0] paddr           = '0;
	logic [DATA_W-1:0] pwdata          = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid        = 1'b0;
	logic              in_ready;
	logic              trigger_request = 1'b0;
	logic              out_valid;
	logic              out_ready       = 1'b0;
	logic              step_level;
	logic              direction_level;
	logic              apnea_alarm;
	logic              breath_active;

	cfg_t               knobs;
	phase_t             ph;
	logic [STEPS_W-1:0] step_count;
	logic [STEPS_W-1:0] step_idx;
	logic [HALF_W-1:0]  inh_half;
	logic [HALF_W-1:0]  exh_half;
	logic [HALF_W-1:0]  half_cnt;
	logic [TMO_W-1:0]   wd_cnt;
	logic               pin;
	logic               trig_latch;

	pins_t     pin_levels_q[$];
	plan_row_t plan[$];
	int        mismatch_cnt   = 0;
	int        cycle_cnt      = 0;
	int        send_gap_pct   = 11;
	int        recv_stall_pct = 85;

	breath_stepper_pulse_controller dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void load_breath();
		int unsigned rate;
		int unsigned part;
		int unsigned deg;
		int unsigned steps;
		int unsigned inh;
		int unsigned exh;
		rate = (knobs.bpm == '0) ? 1 : 32'(knobs.bpm);
		part = PART_NUM / rate;
		if (knobs.vol == VOL_SMALL)
			deg = 32'(knobs.deg_s);
		else if (knobs.vol == VOL_MEDIUM)
			deg = 32'(knobs.deg_m);
		else
			deg = 32'(knobs.deg_l);
		steps = deg * STEPS_REV / DEG_REV;
		if (steps > 32'(STEPS_MAX))
			steps = 32'(STEPS_MAX);
		if (steps == 0)
			steps = 1;
		inh = part / steps;
		exh = part / (2 * steps);
		step_count = STEPS_W'(steps);
		inh_half   = HALF_W'((inh == 0) ? 1 : inh);
		exh_half   = HALF_W'((exh == 0) ? 1 : exh);
		ph         = PH_INHALE;
		step_idx   = '0;
		half_cnt   = '0;
		pin        = 1'b1;
	endfunction

	function automatic pins_t advance_breath(input logic trig);
		pins_t       o;
		int unsigned wd;
		o  = PINS_QUIET;
		wd = 32'(wd_cnt) + 1;
		if (wd >= 32'(knobs.timeout)) begin
			o.alarm    = 1'b1;
			trig_latch = 1'b1;
			wd         = 0;
		end
		trig_latch = trig_latch | trig;
		if (ph == PH_IDLE) begin
			if (knobs.mode == MODE_CTRL || (knobs.mode == MODE_TRIG && trig_latch))
				load_breath();
			trig_latch = 1'b0;
		end
		if (ph != PH_IDLE) begin
			o.step   = pin;
			o.dir    = (ph == PH_INHALE);
			o.active = 1'b1;
			half_cnt = half_cnt + 1'b1;
			if (half_cnt >= ((ph == PH_INHALE) ? inh_half : exh_half)) begin
				half_cnt = '0;
				if (pin) begin
					pin = 1'b0;
				end else begin
					step_idx = step_idx + 1'b1;
					if (step_idx >= step_count) begin
						step_idx = '0;
						if (ph == PH_INHALE) begin
							ph  = PH_EXHALE;
							pin = 1'b1;
						end else begin
							ph  = PH_IDLE;
							pin = 1'b0;
							wd  = 0;
						end
					end else begin
						pin = 1'b1;
					end
				end
			end
		end
		wd_cnt = TMO_W'(wd);
		return o;
	endfunction

	function automatic logic [DATA_W-1:0] pick_edge(input int w);
		logic [DATA_W-1:0] ones;
		ones = (DATA_W'(1) << w) - 1'b1;
		case ($urandom_range(0, 3))
			0: return '0;
			1: return ones;
			default: return $urandom & ones;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_timeout();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return pick_edge(TMO_W);
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	function automatic plan_row_t wr(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		plan_row_t r;
		r          = '0;
		r.is_write = 1'b1;
		r.idx      = idx;
		r.val      = val;
		return r;
	endfunction

	function automatic plan_row_t tk(input logic trig, input logic typed, input pins_t want);
		plan_row_t r;
		r       = '0;
		r.trig  = trig;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	task automatic send_tick(input logic trig, input logic typed, input pins_t want);
		pins_t calc;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		trigger_request <= trig;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		calc = advance_breath(trig);
		pin_levels_q.push_back(typed ? want : calc);
	endtask

	task automatic drain(input int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pin_levels_q.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_BPM:     knobs.bpm     = val[RATE_W-1:0];
			REG_VOL:     knobs.vol     = val[VOL_W-1:0];
			REG_MODE:    knobs.mode    = val[MODE_W-1:0];
			REG_DEG_S:   knobs.deg_s   = val[DEG_W-1:0];
			REG_DEG_M:   knobs.deg_m   = val[DEG_W-1:0];
			REG_DEG_L:   knobs.deg_l   = val[DEG_W-1:0];
			REG_TIMEOUT: knobs.timeout = val[TMO_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_idle_knobs(output logic trig_ok);
		logic [MODE_W-1:0] m;
		drain(4);
		reg_write(REG_BPM, pick_edge(RATE_W));
		reg_write(REG_VOL, $urandom_range(0, 3));
		reg_write(REG_DEG_S, pick_edge(DEG_W));
		reg_write(REG_DEG_M, pick_edge(DEG_W));
		reg_write(REG_DEG_L, pick_edge(DEG_W));
		case ($urandom_range(0, 2))
			0: m = MODE_OFF;
			1: m = MODE_SPARE;
			default: m = MODE_TRIG;
		endcase
		// hold off the watchdog so a triggered mode stays idle
		if (m == MODE_TRIG)
			reg_write(REG_TIMEOUT, DATA_W'({TMO_W{1'b1}}));
		else
			reg_write(REG_TIMEOUT, pick_timeout());
		reg_write(REG_MODE, DATA_W'(m));
		trig_ok = (m != MODE_TRIG);
	endtask

	task automatic set_breath_knobs();
		drain(4);
		reg_write(REG_BPM, ($urandom_range(0, 3) != 0) ? $urandom_range(50, 63)
			: pick_edge(RATE_W));
		reg_write(REG_VOL, $urandom_range(0, 3));
		reg_write(REG_DEG_S, ($urandom_range(0, 3) != 0) ? $urandom_range(921, 1023)
			: pick_edge(DEG_W));
		reg_write(REG_DEG_M, ($urandom_range(0, 3) != 0) ? $urandom_range(921, 1023)
			: pick_edge(DEG_W));
		reg_write(REG_DEG_L, ($urandom_range(0, 3) != 0) ? $urandom_range(921, 1023)
			: pick_edge(DEG_W));
		reg_write(REG_TIMEOUT, $urandom_range(1, 60));
		reg_write(REG_MODE, DATA_W'($urandom_range(0, 1) ? MODE_CTRL : MODE_TRIG));
	endtask

	always @(posedge clk) begin : check_pins
		pins_t got;
		pins_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {step_level, direction_level, apnea_alarm, breath_active};
			if (pin_levels_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= REPORT_MAX)
					$display("unexpected result: step=%b dir=%b alarm=%b active=%b",
						got.step, got.dir, got.alarm, got.active);
			end else begin
				want = pin_levels_q.pop_front();
				if (got.step !== want.step || got.dir !== want.dir ||
						got.alarm !== want.alarm || got.active !== want.active) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_MAX)
						$display({"mismatch: expected step=%b dir=%b alarm=%b ",
							"active=%b, got step=%b dir=%b alarm=%b active=%b"},
							want.step, want.dir, want.alarm, want.active,
							got.step, got.dir, got.alarm, got.active);
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int   seg;
		int   n;
		logic trig_ok;

		knobs = '{bpm: RST_BPM, vol: RST_VOL, mode: RST_MODE, deg_s: RST_DEG_S,
			deg_m: RST_DEG_M, deg_l: RST_DEG_L, timeout: RST_TIMEOUT};
		ph         = PH_IDLE;
		step_count = '0;
		step_idx   = '0;
		inh_half   = '0;
		exh_half   = '0;
		half_cnt   = '0;
		wd_cnt     = '0;
		pin        = 1'b0;
		trig_latch = 1'b0;

		plan.push_back(tk(1'b0, 1'b1, PINS_QUIET));
		plan.push_back(tk(1'b1, 1'b1, PINS_QUIET));
		plan.push_back(wr(REG_TIMEOUT, '0));
		plan.push_back(tk(1'b1, 1'b1, PINS_ALARM));
		plan.push_back(tk(1'b0, 1'b1, PINS_ALARM));
		plan.push_back(wr(REG_MODE, DATA_W'(MODE_SPARE)));
		plan.push_back(wr(REG_TIMEOUT, 4));
		plan.push_back(tk(1'b1, 1'b0, PINS_QUIET));
		plan.push_back(tk(1'b0, 1'b0, PINS_QUIET));
		plan.push_back(tk(1'b1, 1'b0, PINS_QUIET));
		plan.push_back(tk(1'b0, 1'b0, PINS_QUIET));
		plan.push_back(tk(1'b0, 1'b0, PINS_QUIET));
		plan.push_back(tk(1'b1, 1'b0, PINS_QUIET));
		plan.push_back(wr(REG_TIMEOUT, DATA_W'({TMO_W{1'b1}})));
		plan.push_back(wr(REG_BPM, '0));
		plan.push_back(wr(REG_VOL, DATA_W'(VOL_SPARE)));
		plan.push_back(wr(REG_DEG_S, '0));
		plan.push_back(wr(REG_DEG_M, DATA_W'({DEG_W{1'b1}})));
		plan.push_back(wr(REG_DEG_L, 1));
		plan.push_back(wr(REG_MODE, DATA_W'(MODE_TRIG)));
		plan.push_back(tk(1'b0, 1'b1, PINS_QUIET));
		plan.push_back(tk(1'b0, 1'b1, PINS_QUIET));
		plan.push_back(wr(REG_MODE, DATA_W'(MODE_OFF)));
		plan.push_back(tk(1'b1, 1'b1, PINS_QUIET));
		plan.push_back(wr(REG_BPM, DATA_W'({RATE_W{1'b1}})));
		plan.push_back(tk(1'b0, 1'b1, PINS_QUIET));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				drain(4);
				reg_write(plan[i].idx, plan[i].val);
			end else begin
				send_tick(plan[i].trig, plan[i].typed, plan[i].want);
			end
		end

		for (seg = 0; seg < SEGMENTS; seg++) begin
			if (seg == SWAP_SEG) begin
				send_gap_pct   = 85;
				recv_stall_pct = 11;
			end
			if (seg == CALM_SEG) begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
			if (seg < BREATH_SEG) begin
				set_idle_knobs(trig_ok);
			end else if (seg == BREATH_SEG) begin
				set_breath_knobs();
				trig_ok = 1'b1;
			end else begin
				// change knobs mid-breath; only the timeout acts before the next breath
				drain(4);
				reg_write(REG_TIMEOUT, pick_timeout());
				reg_write(reg_idx_t'($urandom_range(0, 5)), $urandom);
			end
			for (n = 0; n < SEG_ITEMS; n++)
				send_tick(trig_ok & ($urandom_range(0, 2) == 0), 1'b0, PINS_QUIET);
		end

		drain(SETTLE);
		if (mismatch_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
